// ===== rtl/bqc_pkg.sv =====
package bqc_pkg;

  // Cascade geometry
  localparam int MAX_SECTIONS   = 8;
  localparam int COEFS_PER_SEC  = 5;
  localparam int DELAYS_PER_SEC = 2;
  localparam int COEF_DEPTH     = MAX_SECTIONS * COEFS_PER_SEC;
  localparam int DLY_DEPTH      = MAX_SECTIONS * DELAYS_PER_SEC;
  localparam int COEF_AW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int DLY_AW         = $clog2(DLY_DEPTH);
  localparam int SEC_W          = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W          = $clog2(MAX_SECTIONS + 1);

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int FRAC_W = 5;
  localparam int PROD_W = 2 * DATA_W;

  // Item kinds
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_COEF     = 2'd1;
  localparam logic [1:0] KIND_DELAY    = 2'd2;
  localparam logic [1:0] KIND_ACTIVATE = 2'd3;

  // Result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVF   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_OFFSET     = 3'd0;
  localparam logic [2:0] REG_SCALE      = 3'd1;
  localparam logic [2:0] REG_SCALE_FRAC = 3'd2;
  localparam logic [2:0] REG_COEFF_FRAC = 3'd3;
  localparam logic [2:0] REG_AUTO       = 3'd4;

  // Request to and response from the shared rounding multiplier
  typedef struct packed {
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [FRAC_W-1:0] frac;
  } mul_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              ovf;
  } mul_rsp_t;

endpackage

// ===== rtl/bqc_ram.sv =====
module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bqc_rmul.sv =====
module bqc_rmul
  import bqc_pkg::*;
(
  input  logic     clk_i,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic        [FRAC_W-1:0] frac_q;
  logic signed [PROD_W-1:0] bias;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;
  logic                     fits;
  mul_rsp_t                 rsp_d, rsp_q;

  // Stage 1: exact signed product
  assign prod_d = $signed(req_i.op_a) * $signed(req_i.op_b);

  // Stage 2: add half an LSB, floor shift, range check
  always_comb begin
    bias    = (frac_q == '0) ? '0 : (PROD_W'(1) <<< (frac_q - FRAC_W'(1)));
    biased  = prod_q + bias;
    shifted = biased >>> frac_q;
    fits    = (&shifted[PROD_W-1:DATA_W-1]) | ~(|shifted[PROD_W-1:DATA_W-1]);
    rsp_d.value = shifted[DATA_W-1:0];
    rsp_d.ovf   = ~fits;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    frac_q <= req_i.frac;
    rsp_q  <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/fixed_point_biquad_cascade.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o   | kind_i, section_i, word_index_i,
//          |           |                           | value_i
// out      | output    | out_valid_o / out_stall_i | result_value_o, status_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load or activate beat, or a sample whose offset sum overflows, goes from S_IDLE
// to S_DONE; any other sample passes S_SCALE, then S_SEC per active section, paced by
// the single shared rounding multiplier (five products per section) and the one read port of each memory.
// Reset clears the configuration, the active count and the valid bits of both
// memories; an entry never written reads as zero, so no clearing pass runs.
// The result sits in an output register: a stalled output holds only that
// register, and the core goes on with the next input beat until it has a new
// result to place there.
module fixed_point_biquad_cascade
  import bqc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic [7:0]               section_i,
  input  logic [2:0]               word_index_i,
  input  logic signed [DATA_W-1:0] value_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic [1:0]               status_o,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCALE = 2'd1;
  localparam logic [1:0] S_SEC   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // Per-section steps: read c0..c4 and z0 z1, five products, write back
  localparam logic [3:0] STEP_P0   = 4'd3;
  localparam logic [3:0] STEP_P1   = 4'd4;
  localparam logic [3:0] STEP_P2   = 4'd5;
  localparam logic [3:0] STEP_P3   = 4'd6;
  localparam logic [3:0] STEP_P4   = 4'd7;
  localparam logic [3:0] STEP_WRZ0 = 4'd8;
  localparam logic [3:0] STEP_WRZ1 = 4'd9;
  localparam logic [3:0] STEP_SCALED = 4'd2;

  logic [1:0]        state_d, state_q;
  logic [3:0]        step_d, step_q;

  // Configuration registers
  logic [DATA_W-1:0] offset_d, offset_q;
  logic [DATA_W-1:0] scale_d, scale_q;
  logic [FRAC_W-1:0] sfrac_d, sfrac_q;
  logic [FRAC_W-1:0] cfrac_d, cfrac_q;
  logic              auto_d, auto_q;

  // Filter control state
  logic [CNT_W-1:0]  active_d, active_q;
  logic [DATA_W-1:0] off_use_d, off_use_q;
  logic              auto_pend_d, auto_pend_q;

  // Datapath
  logic [DATA_W-1:0] x_d, x_q;
  logic [DATA_W-1:0] cur_d, cur_q;
  logic [DATA_W-1:0] nxt_d, nxt_q;
  logic [DATA_W-1:0] z0_d, z0_q;
  logic [DATA_W-1:0] z1_d, z1_q;
  logic [DATA_W-1:0] za_d, za_q;
  logic [DATA_W-1:0] zb_d, zb_q;
  logic              ovf_acc_d, ovf_acc_q;
  logic [SEC_W-1:0]  sec_d, sec_q;
  logic [COEF_AW-1:0] coef_base_d, coef_base_q;
  logic [DLY_AW-1:0] dly_base_d, dly_base_q;

  // Pending result and output register
  logic [DATA_W-1:0] res_value_d, res_value_q;
  logic [1:0]        res_status_d, res_status_q;
  logic              out_valid_d, out_valid_q;
  logic [DATA_W-1:0] out_value_d, out_value_q;
  logic [1:0]        out_status_d, out_status_q;

  // Memories and their valid bits
  logic               coef_we;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [DATA_W-1:0]  coef_wdata, coef_rdata, coef_rd;
  logic               dly_we;
  logic [DLY_AW-1:0]  dly_waddr, dly_raddr;
  logic [DATA_W-1:0]  dly_wdata, dly_rdata, dly_rd;
  logic [COEF_DEPTH-1:0] coef_vld_q;
  logic [DLY_DEPTH-1:0]  dly_vld_q;
  logic                  coef_rvld_q, dly_rvld_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic              in_acc, cfg_we, out_free;
  logic [DATA_W-1:0] off_eff;
  logic [DATA_W:0]   raw_sum;
  logic              sec_ok, last_sec;
  logic [COEF_AW-1:0] coef_ld_addr;
  logic [DLY_AW-1:0]  dly_ld_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // An entry never written reads as zero
  assign coef_rd = coef_rvld_q ? coef_rdata : '0;
  assign dly_rd  = dly_rvld_q ? dly_rdata : '0;

  // Auto capture replaces the offset by the negated raw sample
  assign off_eff = auto_pend_q ? (DATA_W'(0) - value_i) : off_use_q;
  assign raw_sum = {value_i[DATA_W-1], value_i} + {off_eff[DATA_W-1], off_eff};

  assign sec_ok       = section_i < 8'(MAX_SECTIONS);
  assign coef_ld_addr = COEF_AW'(COEF_AW'(section_i[SEC_W-1:0]) * COEF_AW'(COEFS_PER_SEC))
                        + COEF_AW'(word_index_i);
  assign dly_ld_addr  = DLY_AW'(DLY_AW'(section_i[SEC_W-1:0]) * DLY_AW'(DELAYS_PER_SEC))
                        + DLY_AW'(word_index_i[0]);
  assign last_sec     = (CNT_W'(sec_q) + CNT_W'(1)) == active_q;

  // Section reads: coefficient k at step k, z0 at step 0 and z1 at step 1
  assign coef_raddr = coef_base_q + COEF_AW'(step_q[2:0]);
  assign dly_raddr  = dly_base_q + DLY_AW'(step_q[0]);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q + 4'd1;
    offset_d     = offset_q;
    scale_d      = scale_q;
    sfrac_d      = sfrac_q;
    cfrac_d      = cfrac_q;
    auto_d       = auto_q;
    active_d     = active_q;
    off_use_d    = off_use_q;
    auto_pend_d  = auto_pend_q;
    x_d          = x_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    z0_d         = z0_q;
    z1_d         = z1_q;
    za_d         = za_q;
    zb_d         = zb_q;
    ovf_acc_d    = ovf_acc_q;
    sec_d        = sec_q;
    coef_base_d  = coef_base_q;
    dly_base_d   = dly_base_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;

    coef_we    = 1'b0;
    coef_waddr = coef_ld_addr;
    coef_wdata = value_i;
    dly_we     = 1'b0;
    dly_waddr  = dly_ld_addr;
    dly_wdata  = value_i;

    mul_req.op_a = scale_q;
    mul_req.op_b = x_q;
    mul_req.frac = sfrac_q;

    // Drop the output beat once taken
    out_valid_d  = out_valid_q & out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_value_d  = '0;
          res_status_d = STAT_OK;
          state_d      = S_DONE;
          unique case (kind_i)
            KIND_SAMPLE: begin
              if (auto_pend_q) begin
                off_use_d   = off_eff;
                auto_pend_d = 1'b0;
              end
              if (raw_sum[DATA_W] != raw_sum[DATA_W-1]) begin
                res_status_d = STAT_OVF;
              end else begin
                x_d     = raw_sum[DATA_W-1:0];
                step_d  = '0;
                state_d = S_SCALE;
              end
            end
            KIND_COEF: begin
              active_d = '0;
              if (sec_ok && (word_index_i < 3'(COEFS_PER_SEC))) begin
                coef_we = 1'b1;
              end else begin
                res_status_d = STAT_RANGE;
              end
            end
            KIND_DELAY: begin
              active_d = '0;
              if (sec_ok && (word_index_i < 3'(DELAYS_PER_SEC))) begin
                dly_we = 1'b1;
              end else begin
                res_status_d = STAT_RANGE;
              end
            end
            KIND_ACTIVATE: begin
              if (section_i > 8'(MAX_SECTIONS)) begin
                res_status_d = STAT_RANGE;
              end else begin
                active_d = section_i[CNT_W-1:0];
              end
            end
          endcase
        end
      end

      S_SCALE: begin
        // Multiplier runs scale * x; the rounded product shows up at the last step
        if (step_q == STEP_SCALED) begin
          if (mul_rsp.ovf) begin
            res_value_d  = '0;
            res_status_d = STAT_OVF;
            state_d      = S_DONE;
          end else if (active_q == '0) begin
            res_value_d  = mul_rsp.value;
            res_status_d = STAT_OK;
            state_d      = S_DONE;
          end else begin
            cur_d       = mul_rsp.value;
            sec_d       = '0;
            coef_base_d = '0;
            dly_base_d  = '0;
            step_d      = '0;
            state_d     = S_SEC;
          end
        end
      end

      S_SEC: begin
        // Coefficient read data lands in the step after its address
        mul_req.op_a = coef_rd;
        mul_req.op_b = (step_q >= STEP_P1) ? nxt_q : cur_q;
        mul_req.frac = cfrac_q;
        if (step_q == 4'd1) begin
          z0_d = dly_rd;
        end
        if (step_q == 4'd2) begin
          z1_d = dly_rd;
        end
        case (step_q)
          STEP_P0: begin
            nxt_d     = mul_rsp.value + z0_q;
            ovf_acc_d = mul_rsp.ovf;
          end
          STEP_P1: begin
            za_d      = mul_rsp.value;
            ovf_acc_d = ovf_acc_q | mul_rsp.ovf;
          end
          STEP_P2: begin
            zb_d      = mul_rsp.value;
            ovf_acc_d = ovf_acc_q | mul_rsp.ovf;
          end
          STEP_P3: begin
            za_d      = za_q - mul_rsp.value + z1_q;
            ovf_acc_d = ovf_acc_q | mul_rsp.ovf;
          end
          STEP_P4: begin
            zb_d = zb_q - mul_rsp.value;
            // Any overflow in this section leaves its delay words untouched
            if (ovf_acc_q | mul_rsp.ovf) begin
              res_value_d  = '0;
              res_status_d = STAT_OVF;
              state_d      = S_DONE;
            end
          end
          STEP_WRZ0: begin
            dly_we    = 1'b1;
            dly_waddr = dly_base_q;
            dly_wdata = za_q;
          end
          STEP_WRZ1: begin
            dly_we    = 1'b1;
            dly_waddr = dly_base_q + DLY_AW'(1);
            dly_wdata = zb_q;
            cur_d     = nxt_q;
            if (last_sec) begin
              res_value_d  = nxt_q;
              res_status_d = STAT_OK;
              state_d      = S_DONE;
            end else begin
              sec_d       = sec_q + SEC_W'(1);
              coef_base_d = coef_base_q + COEF_AW'(COEFS_PER_SEC);
              dly_base_d  = dly_base_q + DLY_AW'(DELAYS_PER_SEC);
              step_d      = '0;
            end
          end
          default: ;
        endcase
      end

      S_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Register writes must arrive only while idle (not enforced); offset and auto_offset reload the live offset
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_OFFSET: begin
          offset_d    = cfg_data_i;
          off_use_d   = cfg_data_i;
          auto_pend_d = auto_q;
        end
        REG_SCALE:      scale_d = cfg_data_i;
        REG_SCALE_FRAC: sfrac_d = cfg_data_i[FRAC_W-1:0];
        REG_COEFF_FRAC: cfrac_d = cfg_data_i[FRAC_W-1:0];
        REG_AUTO: begin
          auto_d      = cfg_data_i[0];
          off_use_d   = offset_q;
          auto_pend_d = cfg_data_i[0];
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      offset_q    <= '0;
      scale_q     <= '0;
      sfrac_q     <= '0;
      cfrac_q     <= '0;
      auto_q      <= 1'b0;
      active_q    <= '0;
      off_use_q   <= '0;
      auto_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      coef_vld_q  <= '0;
      dly_vld_q   <= '0;
      coef_rvld_q <= 1'b0;
      dly_rvld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      offset_q    <= offset_d;
      scale_q     <= scale_d;
      sfrac_q     <= sfrac_d;
      cfrac_q     <= cfrac_d;
      auto_q      <= auto_d;
      active_q    <= active_d;
      off_use_q   <= off_use_d;
      auto_pend_q <= auto_pend_d;
      out_valid_q <= out_valid_d;
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (dly_we) begin
        dly_vld_q[dly_waddr] <= 1'b1;
      end
      coef_rvld_q <= coef_vld_q[coef_raddr];
      dly_rvld_q  <= dly_vld_q[dly_raddr];
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    x_d_unused_guard: begin
    end
    x_q          <= x_d;
    cur_q        <= cur_d;
    nxt_q        <= nxt_d;
    z0_q         <= z0_d;
    z1_q         <= z1_d;
    za_q         <= za_d;
    zb_q         <= zb_d;
    ovf_acc_q    <= ovf_acc_d;
    sec_q        <= sec_d;
    coef_base_q  <= coef_base_d;
    dly_base_q   <= dly_base_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  bqc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_wdata),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  bqc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DLY_DEPTH)
  ) u_dly_ram (
    .clk_i  (clk_i),
    .we_i   (dly_we),
    .waddr_i(dly_waddr),
    .wdata_i(dly_wdata),
    .raddr_i(dly_raddr),
    .rdata_o(dly_rdata)
  );

  bqc_rmul u_rmul (
    .clk_i(clk_i),
    .req_i(mul_req),
    .rsp_o(mul_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

// ===== dv/fixed_point_biquad_cascade_test.sv =====
`timescale 1ns / 100ps

module fixed_point_biquad_cascade_test;
  import bqc_pkg::*;

  localparam int LONG_HOLD         = 300;  // cycles of output hold-off under pressure
  localparam int RAND_PHASES       = 9;
  localparam int SAMPLES_PER_PHASE = 100;
  localparam int END_SETTLE        = 100;  // longer than a full eight-section sample

  localparam logic [2:0]  REG_SPARE = 3'd7;  // unused register index, must be ignored
  localparam logic [31:0] INT_HI    = 32'h7fff_ffff;
  localparam logic [31:0] INT_LO    = 32'h8000_0000;
  localparam longint      PROD_HI   = 64'sd2147483647;
  localparam longint      PROD_LO   = -64'sd2147483648;

  typedef struct packed {
    logic        drain_first;  // hold this beat until every owed result is back
    logic [1:0]  kind;
    logic [7:0]  section;
    logic [2:0]  word;
    logic [31:0] value;
  } beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] value;
  } rmul_t;

  // DUT ports
  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               kind_i;
  logic [7:0]               section_i;
  logic [2:0]               word_index_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] result_value_o;
  logic [1:0]               status_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [2:0]               cfg_index_i;
  logic [DATA_W-1:0]        cfg_data_i;

  // Stimulus and scoreboard storage
  beat_t   beats_to_send[$];
  result_t owed_results[$];
  beat_t   cur_beat;
  logic    beat_taken;

  // Traffic shaping, shared between the stimulus and the two driving processes
  logic idle_on;
  logic calm;
  logic hold_req;
  int   gap_left;
  int   stall_left;
  int   hold_left;

  // Predictor copy of configuration and state
  logic signed [31:0] offset_reg;
  logic signed [31:0] scale_reg;
  logic [4:0]         scale_frac_reg;
  logic [4:0]         coeff_frac_reg;
  logic               auto_reg;
  logic signed [31:0] coef_mem [COEF_DEPTH];
  logic signed [31:0] dly_mem [DLY_DEPTH];
  int                 active_cnt;
  logic signed [31:0] offset_live;
  logic               auto_armed;

  // Run statistics
  int errors;
  int n_samples, n_loads, n_acts;
  int n_checked, n_ok, n_ovf, n_range;
  int n_cfg, n_holds;

  fixed_point_biquad_cascade u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .section_i      (section_i),
    .word_index_i   (word_index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact product, then round half up and floor-shift by the fraction bits.
  function automatic rmul_t round_mul(input logic signed [31:0] a,
                                      input logic signed [31:0] b,
                                      input logic [4:0] frac);
    rmul_t  r;
    longint p;
    p = longint'(a) * longint'(b);
    if (frac != 0) p = (p + (longint'(1) << (frac - 1))) >>> frac;
    r.value = p[31:0];
    r.ovf   = (p > PROD_HI) || (p < PROD_LO);
    return r;
  endfunction

  // Offset, scale, then walk the active sections. An overflowing section
  // leaves itself and all later sections untouched; earlier ones keep updates.
  function automatic result_t filter_sample(input logic signed [31:0] raw);
    result_t            res;
    longint             total;
    rmul_t              scaled, m0, m1, m2, m3, m4;
    logic signed [31:0] x, y, z0, z1;
    int                 s;
    res.value  = '0;
    res.status = STAT_OVF;
    // auto capture happens before any overflow check, and wraps
    if (auto_armed) begin
      offset_live = 32'sd0 - raw;
      auto_armed  = 1'b0;
    end
    total = longint'(raw) + longint'(offset_live);
    if (total > PROD_HI || total < PROD_LO) return res;
    scaled = round_mul(scale_reg, total[31:0], scale_frac_reg);
    if (scaled.ovf) return res;
    x = scaled.value;
    for (s = 0; s < active_cnt; s++) begin
      z0 = dly_mem[s * DELAYS_PER_SEC];
      z1 = dly_mem[s * DELAYS_PER_SEC + 1];
      m0 = round_mul(coef_mem[s * COEFS_PER_SEC],     x, coeff_frac_reg);
      y  = m0.value + z0;
      m1 = round_mul(coef_mem[s * COEFS_PER_SEC + 1], x, coeff_frac_reg);
      m2 = round_mul(coef_mem[s * COEFS_PER_SEC + 2], x, coeff_frac_reg);
      m3 = round_mul(coef_mem[s * COEFS_PER_SEC + 3], y, coeff_frac_reg);
      m4 = round_mul(coef_mem[s * COEFS_PER_SEC + 4], y, coeff_frac_reg);
      if (m0.ovf || m1.ovf || m2.ovf || m3.ovf || m4.ovf) return res;
      dly_mem[s * DELAYS_PER_SEC]     = m1.value - m3.value + z1;
      dly_mem[s * DELAYS_PER_SEC + 1] = m2.value - m4.value;
      x = y;
    end
    res.value  = x;
    res.status = STAT_OK;
    return res;
  endfunction

  function automatic result_t cascade_step(input beat_t b);
    result_t res;
    res.value  = '0;
    res.status = STAT_OK;
    case (b.kind)
      KIND_SAMPLE: res = filter_sample(b.value);
      KIND_COEF: begin
        // any load drops the cascade, even a rejected one
        active_cnt = 0;
        if (b.section >= MAX_SECTIONS || b.word >= COEFS_PER_SEC) res.status = STAT_RANGE;
        else coef_mem[b.section * COEFS_PER_SEC + b.word] = b.value;
      end
      KIND_DELAY: begin
        active_cnt = 0;
        if (b.section >= MAX_SECTIONS || b.word >= DELAYS_PER_SEC) res.status = STAT_RANGE;
        else dly_mem[b.section * DELAYS_PER_SEC + b.word] = b.value;
      end
      default: begin
        if (b.section > MAX_SECTIONS) res.status = STAT_RANGE;
        else active_cnt = b.section;
      end
    endcase
    return res;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_OFFSET: begin
        offset_reg  = data;
        offset_live = data;
        auto_armed  = auto_reg;
      end
      REG_SCALE:      scale_reg      = data;
      REG_SCALE_FRAC: scale_frac_reg = data[4:0];
      REG_COEFF_FRAC: coeff_frac_reg = data[4:0];
      REG_AUTO: begin
        auto_reg    = data[0];
        offset_live = offset_reg;
        auto_armed  = data[0];
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_beat(input logic [1:0] kind, input int section, input int word,
                                   input logic [31:0] value, input logic drain_first);
    beat_t b;
    b.drain_first = drain_first;
    b.kind        = kind;
    b.section     = section[7:0];
    b.word        = word[2:0];
    b.value       = value;
    beats_to_send.push_back(b);
  endfunction

  // Random signed word with magnitude around 2^bits.
  function automatic logic [31:0] rand_scaled(input int bits);
    logic signed [31:0] r;
    r = $urandom;
    if (bits < 0) bits = 0;
    if (bits > 31) bits = 31;
    return r >>> (31 - bits);
  endfunction

  // Well-formed setup: every coefficient and delay word of n sections, then activate.
  function automatic void load_cascade(input int n, input int cf, input logic zero_dly);
    int s, k;
    for (s = 0; s < n; s++) begin
      for (k = 0; k < COEFS_PER_SEC; k++)
        add_beat(KIND_COEF, s, k, rand_scaled(k < 3 ? cf + 1 : cf - 1), 1'b0);
      for (k = 0; k < DELAYS_PER_SEC; k++)
        add_beat(KIND_DELAY, s, k, zero_dly ? 32'h0 : rand_scaled(cf), 1'b0);
    end
    add_beat(KIND_ACTIVATE, n, $urandom_range(0, 7), $urandom, 1'b0);
  endfunction

  // Config writes happen only with the block idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued beat is in and every owed result is back.
  task automatic settle(input int extra);
    while (beats_to_send.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #4_000_000;
    $display("%0t: timeout with %0d beats queued and %0d results owed",
             $time, beats_to_send.size(), owed_results.size());
    $display("fixed_point_biquad_cascade_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input driver: change at the falling edge, one assignment to valid per step
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive_beats
    logic next_valid;
    next_valid = in_valid_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (!in_valid_i || beat_taken) begin
      // free to move on; a stalled beat stays put untouched
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 3);  // start an idle burst
      end else if (beats_to_send.size() != 0 &&
                   !(beats_to_send[0].drain_first && owed_results.size() != 0)) begin
        cur_beat     = beats_to_send.pop_front();
        kind_i       <= cur_beat.kind;
        section_i    <= cur_beat.section;
        word_index_i <= cur_beat.word;
        value_i      <= cur_beat.value;
        next_valid   = 1'b1;
      end
    end
    beat_taken = 1'b0;
    in_valid_i <= next_valid;
  end

  // Record each accepted beat and predict what it must produce.
  always @(posedge clk_i) begin : take_beats
    result_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      beat_taken = 1'b1;
      r = cascade_step(cur_beat);
      owed_results.push_back(r);
      case (cur_beat.kind)
        KIND_SAMPLE:   n_samples++;
        KIND_ACTIVATE: n_acts++;
        default:       n_loads++;
      endcase
      case (r.status)
        STAT_OK:  n_ok++;
        STAT_OVF: n_ovf++;
        default:  n_range++;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: random bursts, plus one long hold-off counted here
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      n_holds++;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: in-order compare against the oldest owed result
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: expected none, got value %0d status %0d",
                 $time, result_value_o, status_o);
        errors++;
      end else begin
        want = owed_results.pop_front();
        n_checked++;
        if (result_value_o !== want.value) begin
          $display("%0t: result_value mismatch: expected %0d, got %0d",
                   $time, $signed(want.value), result_value_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, status_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int   ph, k, n_sec, cf, sf;
    logic [31:0] offs, scl;

    // known values on every input from time zero
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_SAMPLE;
    section_i    = '0;
    word_index_i = '0;
    value_i      = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_OFFSET;
    cfg_data_i   = '0;
    beat_taken   = 1'b0;
    idle_on      = 1'b1;
    calm         = 1'b0;
    hold_req     = 1'b0;
    gap_left     = 0;
    stall_left   = 0;
    hold_left    = 0;
    errors       = 0;
    n_samples = 0; n_loads = 0; n_acts = 0;
    n_checked = 0; n_ok = 0; n_ovf = 0; n_range = 0;
    n_cfg = 0; n_holds = 0;

    // predictor reset state
    offset_reg = '0; scale_reg = '0; scale_frac_reg = '0; coeff_frac_reg = '0;
    auto_reg = 1'b0; active_cnt = 0; offset_live = '0; auto_armed = 1'b0;
    for (k = 0; k < COEF_DEPTH; k++) coef_mem[k] = '0;
    for (k = 0; k < DLY_DEPTH; k++) dly_mem[k] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: unity gain, Q14 coefficients ---
    write_reg(REG_SCALE, 32'd16);
    write_reg(REG_SCALE_FRAC, 32'd4);
    write_reg(REG_COEFF_FRAC, 32'd14);
    write_reg(REG_OFFSET, 32'd0);
    write_reg(REG_AUTO, 32'd0);
    write_reg(REG_SPARE, 32'hffff_ffff);

    // extremes straight through an empty cascade; junk in ignored fields
    add_beat(KIND_SAMPLE, 0, 0, INT_HI, 1'b0);
    add_beat(KIND_SAMPLE, 255, 7, INT_LO, 1'b0);
    add_beat(KIND_COEF, 0, 0, 1 << 14, 1'b0);
    add_beat(KIND_COEF, 0, 1, 1 << 13, 1'b0);
    add_beat(KIND_COEF, 0, 2, 1 << 12, 1'b0);
    add_beat(KIND_COEF, 0, 3, -(1 << 12), 1'b0);
    add_beat(KIND_COEF, 0, 4, 1 << 10, 1'b0);
    add_beat(KIND_DELAY, 7, 1, INT_LO, 1'b0);   // last delay entry
    add_beat(KIND_COEF, 7, 4, INT_HI, 1'b0);    // last coefficient entry
    // rejected loads and an out-of-range activate, then legal activates each followed by a sample
    add_beat(KIND_COEF, MAX_SECTIONS, 0, 32'd5, 1'b0);
    add_beat(KIND_COEF, 0, 7, 32'd5, 1'b0);
    add_beat(KIND_DELAY, 0, 2, 32'd5, 1'b0);
    add_beat(KIND_DELAY, 255, 7, 32'd5, 1'b0);
    add_beat(KIND_ACTIVATE, MAX_SECTIONS + 1, 0, 32'd0, 1'b0);
    add_beat(KIND_ACTIVATE, 1, 0, 32'd0, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, 32'd1000, 1'b0);
    add_beat(KIND_ACTIVATE, MAX_SECTIONS, 0, 32'd0, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, 32'd12345, 1'b0);
    add_beat(KIND_ACTIVATE, 0, 0, 32'd0, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, 32'd0, 1'b0);
    settle(8);

    // offset overflow, then a legal sample under the same offset
    write_reg(REG_OFFSET, INT_HI);
    add_beat(KIND_SAMPLE, 0, 0, 32'd1, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, -32'sd7, 1'b0);
    settle(8);

    // scale overflow
    write_reg(REG_OFFSET, 32'd0);
    write_reg(REG_SCALE, INT_HI);
    write_reg(REG_SCALE_FRAC, 32'd0);
    add_beat(KIND_SAMPLE, 0, 0, 32'd2, 1'b0);
    settle(8);

    // second section overflows; the first keeps its delay update
    write_reg(REG_SCALE, 32'd16);
    write_reg(REG_SCALE_FRAC, 32'd4);
    add_beat(KIND_COEF, 1, 0, INT_HI, 1'b0);
    add_beat(KIND_ACTIVATE, 2, 0, 32'd0, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, 1 << 20, 1'b0);
    add_beat(KIND_ACTIVATE, 1, 0, 32'd0, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, 32'd0, 1'b0);
    settle(8);

    // auto capture of the most negative sample wraps and then overflows
    write_reg(REG_AUTO, 32'd1);
    add_beat(KIND_SAMPLE, 0, 0, INT_LO, 1'b0);
    add_beat(KIND_SAMPLE, 0, 0, 32'd0, 1'b0);
    settle(8);

    // --- random phases: well-formed setups with random content, plus noise ---
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      calm    = (ph == RAND_PHASES - 1);
      idle_on = (ph % 3 != 2);
      case (ph)
        0:       begin cf = 0;  sf = 31; end
        1:       begin cf = 31; sf = 0;  end
        default: begin cf = $urandom_range(6, 20); sf = $urandom_range(0, 16); end
      endcase
      case (ph)
        2:       offs = INT_LO;
        3:       offs = INT_HI;
        default: offs = rand_scaled($urandom_range(0, 20));
      endcase
      scl = (ph == 4) ? INT_LO : rand_scaled(sf + 1);
      n_sec = (ph == 6) ? MAX_SECTIONS : (ph == 5) ? 1 : $urandom_range(1, 3);

      // upper data bits of the narrow registers must be dropped
      write_reg(REG_SCALE, scl);
      write_reg(REG_SCALE_FRAC, ($urandom & 32'hffff_ffe0) | sf);
      write_reg(REG_COEFF_FRAC, ($urandom & 32'hffff_ffe0) | cf);
      write_reg(REG_OFFSET, offs);
      write_reg(REG_AUTO, ($urandom & 32'hffff_fffe) | ($urandom_range(0, 3) == 0));

      load_cascade(n_sec, cf, $urandom_range(0, 1));
      for (k = 0; k < SAMPLES_PER_PHASE; k++) begin
        case ($urandom_range(0, 39))
          0, 1, 2: begin
            // noise beat; loads in it break the cascade, repair half the time
            add_beat($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 7),
                     $urandom, 1'b0);
            if ($urandom_range(0, 1) == 1)
              add_beat(KIND_ACTIVATE, n_sec, 0, 32'd0, 1'b0);
          end
          3: add_beat(KIND_ACTIVATE, $urandom_range(0, MAX_SECTIONS + 1), 0, 32'd0, 1'b0);
          4: begin
            add_beat(KIND_COEF, $urandom_range(0, n_sec - 1), $urandom_range(0, 4),
                     rand_scaled(cf), 1'b0);
            add_beat(KIND_ACTIVATE, n_sec, 0, 32'd0, 1'b0);
          end
          5: add_beat(KIND_SAMPLE, 0, 0, $urandom_range(0, 1) ? INT_HI : INT_LO,
                      $urandom_range(0, 1));
          6: add_beat(KIND_SAMPLE, 0, 0, $urandom, 1'b1);  // pause until all results are in
          default: add_beat(KIND_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 7),
                            rand_scaled($urandom_range(0, 24)), 1'b0);
        endcase
      end

      // fill the block against a long output hold-off
      if (ph == 5) hold_req = 1'b1;
      settle(8);
    end

    settle(END_SETTLE);

    $display("run covered %0d samples, %0d coefficient or delay loads, %0d activates, %0d config writes",
             n_samples, n_loads, n_acts, n_cfg);
    $display("checked %0d results: %0d ok, %0d overflow, %0d out of range; %0d long hold-offs",
             n_checked, n_ok, n_ovf, n_range, n_holds);
    if (errors == 0) begin
      $display("fixed_point_biquad_cascade_test: clean");
    end else begin
      $display("fixed_point_biquad_cascade_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bqc_pkg.sv
rtl/bqc_ram.sv
rtl/bqc_rmul.sv
rtl/fixed_point_biquad_cascade.sv
dv/fixed_point_biquad_cascade_test.sv
